// ----- sv/mfd_pkg.sv -----
// Shared types, field widths and codes for the Dinic max-flow engine.
// No dependencies; the interfaces, the engine core and the checker import it.
package mfd_pkg;

    localparam int MAX_VERTICES_D = 64;
    localparam int MAX_EDGES_D    = 256;
    localparam int CAP_BITS_D     = 32;

    localparam int CMD_W    = 2;
    localparam int VTX_W    = 6;
    localparam int ECAP_W   = 32;
    localparam int ENUM_W   = 8;
    localparam int FLOW_W   = 40;
    localparam int EFLOW_W  = 32;
    localparam int STATUS_W = 2;
    localparam int VC_W     = 7;
    localparam int VC_RESET = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ----- sv/mfd_cmd_if.sv -----
// Command channel: one word carries one command and its operands.
// Depends on mfd_pkg.
interface mfd_cmd_if;
    import mfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [VTX_W-1:0]    edge_tail;
    logic [VTX_W-1:0]    edge_head;
    logic [ECAP_W-1:0]   edge_capacity;
    logic [ENUM_W-1:0]   edge_number;

    modport source (output valid, command, edge_tail, edge_head, edge_capacity, edge_number,
                    input ready);
    modport sink   (input valid, command, edge_tail, edge_head, edge_capacity, edge_number,
                    output ready);
endinterface

// ----- sv/mfd_res_if.sv -----
// Result channel: one word per command.
// Depends on mfd_pkg.
interface mfd_res_if;
    import mfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [FLOW_W-1:0]   total_flow;
    logic [EFLOW_W-1:0]  edge_flow;
    logic [STATUS_W-1:0] status;

    modport source (output valid, total_flow, edge_flow, status, input ready);
    modport sink   (input valid, total_flow, edge_flow, status, output ready);
endinterface

// ----- sv/mfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfd_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/max_flow_dinic_engine_core.sv -----
// Dinic max-flow engine. One word at a time; ready is low while a command runs.
// Clear: empties lists, arc count, flow sum. Add edge: arc, then its reverse.
// Read: one flow RAM lookup. Solve: data dependent, set by the sequencer walking
// arc lists through the one-read-port arc RAMs in level search, augmentation and
// path update. A finished word waits in the output register.
// Reset (sync, active low): lists empty, flow sum 0, vertex count 2.
module max_flow_dinic_engine_core #(
    parameter int MAX_VERTICES = mfd_pkg::MAX_VERTICES_D,
    parameter int MAX_EDGES    = mfd_pkg::MAX_EDGES_D,
    parameter int CAP_BITS     = mfd_pkg::CAP_BITS_D
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [mfd_pkg::VC_W-1:0] i_cfg_data,
    mfd_cmd_if.sink                  i_cmd,
    mfd_res_if.source                o_res
);
    import mfd_pkg::*;

    localparam int ARC_DEPTH = 2 * MAX_EDGES;
    localparam int AIW = $clog2(ARC_DEPTH);
    localparam int AW  = AIW + 1;
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int CB  = CAP_BITS;
    localparam int SW  = AW + VW + 1 + CB;
    localparam logic [AW-1:0] NIL = AW'(ARC_DEPTH);

    typedef enum logic [29:0] {
        S_IDLE     = 30'd1 << 0,
        S_DONE     = 30'd1 << 1,
        S_ADD_RD   = 30'd1 << 2,
        S_ADD_LNK  = 30'd1 << 3,
        S_RD_W     = 30'd1 << 4,
        S_RD_OUT   = 30'd1 << 5,
        S_BFS_INIT = 30'd1 << 6,
        S_BFS_POP  = 30'd1 << 7,
        S_BFS_U    = 30'd1 << 8,
        S_BFS_U2   = 30'd1 << 9,
        S_BFS_ARC  = 30'd1 << 10,
        S_BFS_CHK  = 30'd1 << 11,
        S_AUG_INIT = 30'd1 << 12,
        S_AUG_V    = 30'd1 << 13,
        S_AUG_CUR  = 30'd1 << 14,
        S_AUG_ARC  = 30'd1 << 15,
        S_AUG_T    = 30'd1 << 16,
        S_AUG_LV   = 30'd1 << 17,
        S_AUG_ADV  = 30'd1 << 18,
        S_AUG_FAIL = 30'd1 << 19,
        S_AUG_POP  = 30'd1 << 20,
        S_AUG_PLW  = 30'd1 << 21,
        S_AUG_PADV = 30'd1 << 22,
        S_AUG_SINK = 30'd1 << 23,
        S_AUG_WALK = 30'd1 << 24,
        S_AUG_UP1  = 30'd1 << 25,
        S_AUG_UP2  = 30'd1 << 26,
        S_AUG_UP3  = 30'd1 << 27,
        S_AUG_UP4  = 30'd1 << 28,
        S_AUG_UP5  = 30'd1 << 29
    } t_state;

    t_state r_state, n_state;
    logic [VC_W-1:0]         r_vc;
    logic [AW-1:0]           r_atot, n_atot;
    logic [FLOW_W-1:0]       r_sum, n_sum;
    logic [MAX_VERTICES-1:0] r_list_ok, n_list_ok;
    logic [MAX_VERTICES-1:0] r_lvl_ok, n_lvl_ok;
    logic [MAX_VERTICES-1:0] r_cur_ok, n_cur_ok;
    logic                    r_ov, n_ov;

    logic [VW-1:0]      r_from, n_from, r_to, n_to, r_u, n_u, r_v, n_v, r_t, n_t;
    logic [CB-1:0]      r_c, n_c, r_lim, n_lim, r_room, n_room;
    logic               r_second, n_second, r_lim_inf, n_lim_inf;
    logic [NW-1:0]      r_head, n_head, r_tail, n_tail, r_sp, n_sp, r_wp, n_wp;
    logic [NW-1:0]      r_lvl_u, n_lvl_u, r_lvl_v, n_lvl_v;
    logic [AW-1:0]      r_arc, n_arc, r_link, n_link;
    logic [EFLOW_W-1:0] r_eflow, n_eflow, r_oefl, n_oefl;
    t_status            r_status, n_status, r_ost, n_ost;
    logic [FLOW_W-1:0]  r_otot, n_otot;

    // RAM ports
    logic tgt_we, cap_we, flw_we, lnk_we, first_we, last_we, lvl_we, cur_we, que_we, stk_we;
    logic [AIW-1:0] tgt_wa, cap_wa, flw_wa, lnk_wa;
    logic [VW-1:0]  first_wa, last_wa, lvl_wa, cur_wa, que_wa, stk_wa;
    logic [VW-1:0]  tgt_wd, tgt_rd, que_wd, que_rd;
    logic [CB-1:0]  cap_wd, cap_rd;
    logic [CB:0]    flw_wd, flw_rd;
    logic [AW-1:0]  lnk_wd, lnk_rd, first_wd, first_rd, last_wd, last_rd, cur_wd, cur_rd;
    logic [NW-1:0]  lvl_wd, lvl_rd;
    logic [SW-1:0]  stk_wd, stk_rd;
    logic [VW-1:0]  first_ra, lvl_ra, stk_ra;

    logic [NW-1:0] n_live;
    logic [VW-1:0] sink;
    logic [CB:0]   room_full;

    always_comb begin
        if (r_vc < VC_W'(2)) begin
            n_live = NW'(2);
        end else if (32'(r_vc) > 32'(MAX_VERTICES)) begin
            n_live = NW'(MAX_VERTICES);
        end else begin
            n_live = NW'(r_vc);
        end
    end
    assign sink      = VW'(n_live - NW'(1));
    assign room_full = {1'b0, cap_rd} - flw_rd;

    assign first_ra = (r_state == S_BFS_U) ? que_rd : r_v;
    assign lvl_ra   = (r_state == S_BFS_U) ? que_rd : tgt_rd;
    assign stk_ra   = (r_state == S_AUG_WALK) ? VW'(r_wp - NW'(1)) : VW'(r_sp - NW'(1));

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.total_flow = r_otot;
    assign o_res.edge_flow  = r_oefl;
    assign o_res.status     = r_ost;

    always_comb begin
        n_state = r_state;   n_atot = r_atot;     n_sum = r_sum;
        n_list_ok = r_list_ok; n_lvl_ok = r_lvl_ok; n_cur_ok = r_cur_ok;
        n_ov = r_ov;         n_from = r_from;     n_to = r_to;   n_u = r_u;
        n_v = r_v;           n_t = r_t;           n_c = r_c;     n_lim = r_lim;
        n_room = r_room;     n_second = r_second; n_lim_inf = r_lim_inf;
        n_head = r_head;     n_tail = r_tail;     n_sp = r_sp;   n_wp = r_wp;
        n_lvl_u = r_lvl_u;   n_lvl_v = r_lvl_v;   n_arc = r_arc; n_link = r_link;
        n_eflow = r_eflow;   n_status = r_status; n_ost = r_ost;
        n_oefl = r_oefl;     n_otot = r_otot;

        tgt_we = 1'b0; cap_we = 1'b0; flw_we = 1'b0; lnk_we = 1'b0; first_we = 1'b0;
        last_we = 1'b0; lvl_we = 1'b0; cur_we = 1'b0; que_we = 1'b0; stk_we = 1'b0;
        tgt_wa = r_atot[AIW-1:0]; cap_wa = r_atot[AIW-1:0];
        flw_wa = r_arc[AIW-1:0];  lnk_wa = r_atot[AIW-1:0];
        tgt_wd = r_to; cap_wd = r_c; flw_wd = '0; lnk_wd = NIL;
        first_wa = r_from; first_wd = r_atot; last_wa = r_from; last_wd = r_atot;
        lvl_wa = '0; lvl_wd = '0; cur_wa = r_v; cur_wd = r_link;
        que_wa = '0; que_wd = '0;
        stk_wa = r_sp[VW-1:0]; stk_wd = {r_arc, r_v, r_lim_inf, r_lim};

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_eflow  = '0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (t_cmd'(i_cmd.command))
                        CMD_CLEAR: begin
                            n_list_ok = '0;
                            n_lvl_ok  = '0;
                            n_cur_ok  = '0;
                            n_atot    = '0;
                            n_sum     = '0;
                        end
                        CMD_ADD: begin
                            if (32'(i_cmd.edge_tail) >= 32'(n_live) ||
                                32'(i_cmd.edge_head) >= 32'(n_live)) begin
                                n_status = ST_RANGE;
                            end else if (32'(r_atot) + 32'd2 > 32'(ARC_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_from   = VW'(i_cmd.edge_tail);
                                n_to     = VW'(i_cmd.edge_head);
                                n_c      = CB'(i_cmd.edge_capacity);
                                n_second = 1'b0;
                                n_state  = S_ADD_RD;
                            end
                        end
                        CMD_SOLVE: begin
                            n_state = S_BFS_INIT;
                        end
                        CMD_READ: begin
                            if ((32'(i_cmd.edge_number) << 1) < 32'(r_atot)) begin
                                n_arc   = AW'(32'(i_cmd.edge_number) << 1);
                                n_state = S_RD_W;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_otot  = r_sum;
                    n_oefl  = r_eflow;
                    n_ost   = r_status;
                    n_state = S_IDLE;
                end
            end
            S_ADD_RD: begin
                tgt_we = 1'b1; cap_we = 1'b1; lnk_we = 1'b1;
                flw_we = 1'b1; flw_wa = r_atot[AIW-1:0];
                n_state = S_ADD_LNK;
            end
            S_ADD_LNK: begin
                if (r_list_ok[r_from]) begin
                    lnk_we = 1'b1;
                    lnk_wa = last_rd[AIW-1:0];
                    lnk_wd = r_atot;
                end else begin
                    first_we = 1'b1;
                    n_list_ok[r_from] = 1'b1;
                end
                last_we = 1'b1;
                n_atot  = r_atot + AW'(1);
                if (!r_second) begin
                    n_from = r_to; n_to = r_from; n_c = '0; n_second = 1'b1;
                    n_state = S_ADD_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD_W: n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (!flw_rd[CB] && flw_rd != '0) begin
                    n_eflow = EFLOW_W'(flw_rd[CB-1:0]);
                end
                n_state = S_DONE;
            end
            S_BFS_INIT: begin
                n_lvl_ok = MAX_VERTICES'(1);
                lvl_we = 1'b1; que_we = 1'b1;
                n_head = '0; n_tail = NW'(1);
                n_state = S_BFS_POP;
            end
            S_BFS_POP: begin
                if (r_lvl_ok[sink]) begin
                    n_state = S_AUG_INIT;
                end else if (r_head < r_tail) begin
                    n_head  = r_head + NW'(1);
                    n_state = S_BFS_U;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BFS_U: begin
                n_u = que_rd;
                n_state = S_BFS_U2;
            end
            S_BFS_U2: begin
                n_lvl_u = lvl_rd;
                n_arc   = r_list_ok[r_u] ? first_rd : NIL;
                n_state = S_BFS_ARC;
            end
            S_BFS_ARC: n_state = (r_arc >= NIL) ? S_BFS_POP : S_BFS_CHK;
            S_BFS_CHK: begin
                if (NW'(tgt_rd) < n_live && !r_lvl_ok[tgt_rd] &&
                    $signed(flw_rd) < $signed({1'b0, cap_rd})) begin
                    n_lvl_ok[tgt_rd] = 1'b1;
                    lvl_we = 1'b1; lvl_wa = tgt_rd; lvl_wd = r_lvl_u + NW'(1);
                    if (r_tail < NW'(MAX_VERTICES)) begin
                        que_we = 1'b1; que_wa = r_tail[VW-1:0]; que_wd = tgt_rd;
                        n_tail = r_tail + NW'(1);
                    end
                end
                n_arc   = lnk_rd;
                n_state = S_BFS_ARC;
            end
            S_AUG_INIT: begin
                n_cur_ok = '0;
                n_v = '0; n_lvl_v = '0; n_lim_inf = 1'b1; n_lim = '0; n_sp = '0;
                n_state = S_AUG_V;
            end
            S_AUG_V: begin
                if (!r_lim_inf && r_lim == '0) begin
                    n_state = S_AUG_FAIL;
                end else if (r_v == sink) begin
                    n_state = S_AUG_SINK;
                end else begin
                    n_state = S_AUG_CUR;
                end
            end
            S_AUG_CUR: begin
                n_arc = r_cur_ok[r_v] ? cur_rd : (r_list_ok[r_v] ? first_rd : NIL);
                n_state = S_AUG_ARC;
            end
            S_AUG_ARC: n_state = (r_arc >= NIL) ? S_AUG_FAIL : S_AUG_T;
            S_AUG_T: begin
                n_t    = tgt_rd;
                n_room = room_full[CB-1:0];
                n_link = lnk_rd;
                n_state = (NW'(tgt_rd) < n_live && r_lvl_ok[tgt_rd]) ? S_AUG_LV : S_AUG_ADV;
            end
            S_AUG_LV: begin
                if (lvl_rd == r_lvl_v + NW'(1)) begin
                    stk_we  = 1'b1;
                    n_sp    = r_sp + NW'(1);
                    n_v     = r_t;
                    n_lvl_v = r_lvl_v + NW'(1);
                    n_lim_inf = 1'b0;
                    n_lim   = (r_lim_inf || r_room <= r_lim) ? r_room : r_lim;
                    n_state = S_AUG_V;
                end else begin
                    n_state = S_AUG_ADV;
                end
            end
            S_AUG_ADV: begin
                cur_we = 1'b1;
                n_cur_ok[r_v] = 1'b1;
                n_arc   = r_link;
                n_state = S_AUG_ARC;
            end
            S_AUG_FAIL: begin
                if (r_sp == '0) begin
                    n_state = S_BFS_INIT;
                end else begin
                    n_sp    = r_sp - NW'(1);
                    n_state = S_AUG_POP;
                end
            end
            S_AUG_POP: begin
                {n_arc, n_v, n_lim_inf, n_lim} = stk_rd;
                n_lvl_v = r_lvl_v - NW'(1);
                n_state = S_AUG_PLW;
            end
            S_AUG_PLW: n_state = S_AUG_PADV;
            S_AUG_PADV: begin
                cur_we = 1'b1; cur_wd = lnk_rd;
                n_cur_ok[r_v] = 1'b1;
                n_arc   = lnk_rd;
                n_state = S_AUG_ARC;
            end
            S_AUG_SINK: begin
                n_sum   = FLOW_W'(r_sum + FLOW_W'(r_lim));
                n_wp    = r_sp;
                n_state = S_AUG_WALK;
            end
            S_AUG_WALK: begin
                if (r_wp == '0) begin
                    n_v = '0; n_lvl_v = '0; n_lim_inf = 1'b1; n_lim = '0; n_sp = '0;
                    n_state = S_AUG_V;
                end else begin
                    n_wp    = r_wp - NW'(1);
                    n_state = S_AUG_UP1;
                end
            end
            S_AUG_UP1: begin
                n_arc   = stk_rd[SW-1 -: AW];
                n_state = S_AUG_UP2;
            end
            S_AUG_UP2: n_state = S_AUG_UP3;
            S_AUG_UP3: begin
                flw_we = 1'b1; flw_wd = flw_rd + {1'b0, r_lim};
                n_arc   = {r_arc[AW-1:1], ~r_arc[0]};
                n_state = S_AUG_UP4;
            end
            S_AUG_UP4: n_state = S_AUG_UP5;
            S_AUG_UP5: begin
                flw_we = 1'b1; flw_wd = flw_rd - {1'b0, r_lim};
                n_state = S_AUG_WALK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vc      <= VC_W'(VC_RESET);
            r_atot    <= '0;
            r_sum     <= '0;
            r_list_ok <= '0;
            r_lvl_ok  <= '0;
            r_cur_ok  <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            r_atot    <= n_atot;
            r_sum     <= n_sum;
            r_list_ok <= n_list_ok;
            r_lvl_ok  <= n_lvl_ok;
            r_cur_ok  <= n_cur_ok;
            r_ov      <= n_ov;
        end
        r_from <= n_from; r_to <= n_to; r_u <= n_u; r_v <= n_v; r_t <= n_t;
        r_c <= n_c; r_lim <= n_lim; r_room <= n_room;
        r_second <= n_second; r_lim_inf <= n_lim_inf;
        r_head <= n_head; r_tail <= n_tail; r_sp <= n_sp; r_wp <= n_wp;
        r_lvl_u <= n_lvl_u; r_lvl_v <= n_lvl_v; r_arc <= n_arc; r_link <= n_link;
        r_eflow <= n_eflow; r_status <= n_status;
        r_ost <= n_ost; r_oefl <= n_oefl; r_otot <= n_otot;
    end

    mfd_ram #(.W(VW), .D(ARC_DEPTH)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_raddr(r_arc[AIW-1:0]), .o_rdata(tgt_rd));
    mfd_ram #(.W(CB), .D(ARC_DEPTH)) u_cap (
        .i_clk(i_clk), .i_we(cap_we), .i_waddr(cap_wa), .i_wdata(cap_wd),
        .i_raddr(r_arc[AIW-1:0]), .o_rdata(cap_rd));
    mfd_ram #(.W(CB + 1), .D(ARC_DEPTH)) u_flw (
        .i_clk(i_clk), .i_we(flw_we), .i_waddr(flw_wa), .i_wdata(flw_wd),
        .i_raddr(r_arc[AIW-1:0]), .o_rdata(flw_rd));
    mfd_ram #(.W(AW), .D(ARC_DEPTH)) u_lnk (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(r_arc[AIW-1:0]), .o_rdata(lnk_rd));
    mfd_ram #(.W(AW), .D(MAX_VERTICES)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(first_wa), .i_wdata(first_wd),
        .i_raddr(first_ra), .o_rdata(first_rd));
    mfd_ram #(.W(AW), .D(MAX_VERTICES)) u_last (
        .i_clk(i_clk), .i_we(last_we), .i_waddr(last_wa), .i_wdata(last_wd),
        .i_raddr(r_from), .o_rdata(last_rd));
    mfd_ram #(.W(NW), .D(MAX_VERTICES)) u_lvl (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_wa), .i_wdata(lvl_wd),
        .i_raddr(lvl_ra), .o_rdata(lvl_rd));
    mfd_ram #(.W(AW), .D(MAX_VERTICES)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(r_v), .o_rdata(cur_rd));
    mfd_ram #(.W(VW), .D(MAX_VERTICES)) u_que (
        .i_clk(i_clk), .i_we(que_we), .i_waddr(que_wa), .i_wdata(que_wd),
        .i_raddr(r_head[VW-1:0]), .o_rdata(que_rd));
    mfd_ram #(.W(SW), .D(MAX_VERTICES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));
endmodule

// ----- sv/mfd_checker.sv -----
// Port-level checks for the max-flow engine, bound to the top level.
// Depends on mfd_pkg and max_flow_dinic_engine_core.
module mfd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [mfd_pkg::STATUS_W-1:0] i_status,
    input logic [mfd_pkg::EFLOW_W-1:0]  i_edge_flow
);
    import mfd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before taken");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_FULL || i_status == ST_RANGE))
        else $error("bad status code");

    a_flow_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_edge_flow != '0 |-> i_status == ST_OK)
        else $error("edge flow on failed command");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready held after accept");
endmodule

bind max_flow_dinic_engine_core mfd_checker u_mfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_edge_flow (o_res.edge_flow)
);
